/* src/cclim_pkg.sv */
// ----------------------------------------------------------------------------
// cclim_pkg: shared types and constants of the count change alert limiter
// Widths, register indexes, reset values and the per-channel decision types.
// ----------------------------------------------------------------------------
package cclim_pkg;

	localparam int COUNT_BITS = 16;
	localparam int TIME_BITS  = 32;
	localparam int CFG_BITS   = 32;
	localparam int IDX_BITS   = 3;
	localparam int NUM_CHAN   = 3;

	// configuration register indexes
	localparam logic [IDX_BITS-1:0] REG_UNREAD_DELTA = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_UNDONE_DELTA = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_LATE_DELTA   = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_UNREAD_GAP   = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_UNDONE_GAP   = 3'd4;
	localparam logic [IDX_BITS-1:0] REG_LATE_GAP     = 3'd5;
	localparam logic [IDX_BITS-1:0] REG_GROUP_MODE   = 3'd6;

	// channel codes
	localparam logic [1:0] CH_UNREAD = 2'd0;
	localparam logic [1:0] CH_UNDONE = 2'd1;
	localparam logic [1:0] CH_LATE   = 2'd2;

	// reset values of the registers
	localparam logic [COUNT_BITS-1:0] RST_UNREAD_DELTA = 16'd3;
	localparam logic [COUNT_BITS-1:0] RST_UNDONE_DELTA = 16'd2;
	localparam logic [COUNT_BITS-1:0] RST_LATE_DELTA   = 16'd1;
	localparam logic [TIME_BITS-1:0]  RST_UNREAD_GAP   = 32'd300000;
	localparam logic [TIME_BITS-1:0]  RST_UNDONE_GAP   = 32'd600000;
	localparam logic [TIME_BITS-1:0]  RST_LATE_GAP     = 32'd900000;

	// decision of one channel for one sample
	typedef struct packed {
		logic emit;    // a word goes out for this channel
		logic fire;    // real alert, alert point moves
		logic rising;  // count rose against the previous sample
	} chan_dec_t;

	// one buffered result word
	typedef struct packed {
		logic [1:0]            channel;
		logic                  suppressed;
		logic [COUNT_BITS-1:0] count_value;
		logic                  rising;
	} res_t;

endpackage

/* src/count_change_alert_limiter.sv */
// ----------------------------------------------------------------------------
// count_change_alert_limiter: rate limited alerts on counter changes
// Watches the unread, undone and late counts of timestamped samples and
// gives real or suppressed alert words, in channel order, per sample.
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | words
//  ---------+---------------------+-------------------------------------------
//  input    | in_valid/in_ready   | now_ms, four counts, work_session
//  output   | out_valid/out_ready | channel, suppressed, count_value, rising,
//           |                     | last_of_run
//  config   | cfg_we              | cfg_index, cfg_data (write only)
//
//  A sample is registered, then evaluated into a three word result buffer;
//  its words leave one per cycle while out_ready is high, from the next cycle
//  on, so the output port sets the rate of samples.
//  A new sample is taken while the last buffered word is being taken.
//  Reset clears the baselines, alert points and registers to their defaults.
//
module count_change_alert_limiter (
	input  logic                                clk,
	input  logic                                arst_n,
	// input channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [cclim_pkg::TIME_BITS-1:0]     now_ms,
	input  logic [cclim_pkg::COUNT_BITS-1:0]    unread_count,
	input  logic [cclim_pkg::COUNT_BITS-1:0]    undone_count,
	input  logic [cclim_pkg::COUNT_BITS-1:0]    expired_count,
	input  logic [cclim_pkg::COUNT_BITS-1:0]    group_delayed_count,
	input  logic                                work_session,
	// output channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          channel,
	output logic                                suppressed,
	output logic [cclim_pkg::COUNT_BITS-1:0]    count_value,
	output logic                                rising,
	output logic                                last_of_run,
	// configuration
	input  logic                                cfg_we,
	input  logic [cclim_pkg::IDX_BITS-1:0]      cfg_index,
	input  logic [cclim_pkg::CFG_BITS-1:0]      cfg_data
);

	localparam int CB = cclim_pkg::COUNT_BITS;
	localparam int TB = cclim_pkg::TIME_BITS;

	// configuration registers
	logic [CB-1:0] delta_q [3];
	logic [TB-1:0] gap_q   [3];
	logic          group_mode_q;

	// input stage
	logic          valid_s1;
	logic [TB-1:0] now_s1;
	logic [CB-1:0] unread_s1;
	logic [CB-1:0] undone_s1;
	logic [CB-1:0] expired_s1;
	logic [CB-1:0] grp_s1;
	logic          work_s1;

	// sample state
	logic          base_valid_q;
	logic [CB-1:0] prev_unread_q;
	logic [CB-1:0] prev_undone_q;
	logic [CB-1:0] prev_expired_q;
	logic [CB-1:0] prev_grp_q;
	logic [CB-1:0] alert_cnt_q  [3];
	logic [TB-1:0] alert_time_q [3];

	// result buffer
	cclim_pkg::res_t res_q [3];
	logic [1:0]      rem_q;
	logic [1:0]      ptr_q;

	logic                 buf_free;
	logic                 eval;
	logic [CB-1:0]        cur    [3];
	logic [CB-1:0]        prev   [3];
	cclim_pkg::chan_dec_t dec    [3];
	cclim_pkg::res_t      word   [3];
	logic [1:0]           nwords;
	cclim_pkg::res_t      head;

	// handshake
	assign out_valid = (rem_q != 2'd0);
	assign buf_free  = (rem_q == 2'd0) || (rem_q == 2'd1 && out_ready);
	assign eval      = valid_s1 && buf_free;
	assign in_ready  = !valid_s1 || buf_free;

	// pick the counts of each channel
	always_comb begin
		cur[0]  = unread_s1;
		cur[1]  = undone_s1;
		cur[2]  = group_mode_q ? grp_s1 : expired_s1;
		prev[0] = prev_unread_q;
		prev[1] = prev_undone_q;
		prev[2] = group_mode_q ? prev_grp_q : prev_expired_q;
	end

	// decide each channel
	for (genvar g = 0; g < cclim_pkg::NUM_CHAN; g++) begin : g_chan
		cclim_chan u_chan (
			.prev       (prev[g]),
			.cur        (cur[g]),
			.alert_cnt  (alert_cnt_q[g]),
			.alert_time (alert_time_q[g]),
			.now        (now_s1),
			.delta      (delta_q[g]),
			.gap        (gap_q[g]),
			.work       (work_s1),
			.dec        (dec[g])
		);
		assign word[g].channel     = 2'(g);
		assign word[g].suppressed  = !dec[g].fire;
		assign word[g].count_value = cur[g];
		assign word[g].rising      = dec[g].rising;
	end

	assign nwords = {1'b0, dec[0].emit} + {1'b0, dec[1].emit} + {1'b0, dec[2].emit};

	// present the head word
	always_comb begin
		case (ptr_q)
			2'd0:    head = res_q[0];
			2'd1:    head = res_q[1];
			default: head = res_q[2];
		endcase
		channel     = head.channel;
		suppressed  = head.suppressed;
		count_value = head.count_value;
		rising      = head.rising;
		last_of_run = (rem_q == 2'd1);
	end

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_q[0]   <= cclim_pkg::RST_UNREAD_DELTA;
			delta_q[1]   <= cclim_pkg::RST_UNDONE_DELTA;
			delta_q[2]   <= cclim_pkg::RST_LATE_DELTA;
			gap_q[0]     <= cclim_pkg::RST_UNREAD_GAP;
			gap_q[1]     <= cclim_pkg::RST_UNDONE_GAP;
			gap_q[2]     <= cclim_pkg::RST_LATE_GAP;
			group_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cclim_pkg::REG_UNREAD_DELTA: delta_q[0]   <= cfg_data[CB-1:0];
				cclim_pkg::REG_UNDONE_DELTA: delta_q[1]   <= cfg_data[CB-1:0];
				cclim_pkg::REG_LATE_DELTA:   delta_q[2]   <= cfg_data[CB-1:0];
				cclim_pkg::REG_UNREAD_GAP:   gap_q[0]     <= cfg_data[TB-1:0];
				cclim_pkg::REG_UNDONE_GAP:   gap_q[1]     <= cfg_data[TB-1:0];
				cclim_pkg::REG_LATE_GAP:     gap_q[2]     <= cfg_data[TB-1:0];
				cclim_pkg::REG_GROUP_MODE:   group_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// hold the accepted sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			now_s1     <= now_ms;
			unread_s1  <= unread_count;
			undone_s1  <= undone_count;
			expired_s1 <= expired_count;
			grp_s1     <= group_delayed_count;
			work_s1    <= work_session;
		end
	end

	// advance baselines and alert points
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_valid_q   <= 1'b0;
			prev_unread_q  <= '0;
			prev_undone_q  <= '0;
			prev_expired_q <= '0;
			prev_grp_q     <= '0;
			for (int i = 0; i < 3; i++) begin
				alert_cnt_q[i]  <= '0;
				alert_time_q[i] <= '0;
			end
		end else if (eval) begin
			base_valid_q   <= 1'b1;
			prev_unread_q  <= unread_s1;
			prev_undone_q  <= undone_s1;
			prev_expired_q <= expired_s1;
			prev_grp_q     <= grp_s1;
			for (int i = 0; i < 3; i++) begin
				if (!base_valid_q || dec[i].fire) begin
					alert_cnt_q[i]  <= cur[i];
					alert_time_q[i] <= now_s1;
				end
			end
		end
	end

	// load the result buffer packed in channel order, drain one word a cycle while out_ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
			ptr_q <= 2'd0;
		end else if (eval) begin
			rem_q <= base_valid_q ? nwords : 2'd0;
			ptr_q <= 2'd0;
		end else if (out_valid && out_ready) begin
			rem_q <= rem_q - 2'd1;
			ptr_q <= ptr_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (eval) begin
			res_q[0] <= dec[0].emit ? word[0] : (dec[1].emit ? word[1] : word[2]);
			res_q[1] <= (dec[0].emit && dec[1].emit) ? word[1] : word[2];
			res_q[2] <= word[2];
		end
	end

endmodule

/* src/cclim_chan.sv */
// ----------------------------------------------------------------------------
// cclim_chan: alert decision of one channel
// Compares a channel's count with its previous sample and its alert point
// and decides between a real alert, a suppressed notice or nothing.
// ----------------------------------------------------------------------------
module cclim_chan (
	input  logic [cclim_pkg::COUNT_BITS-1:0] prev,
	input  logic [cclim_pkg::COUNT_BITS-1:0] cur,
	input  logic [cclim_pkg::COUNT_BITS-1:0] alert_cnt,
	input  logic [cclim_pkg::TIME_BITS-1:0]  alert_time,
	input  logic [cclim_pkg::TIME_BITS-1:0]  now,
	input  logic [cclim_pkg::COUNT_BITS-1:0] delta,
	input  logic [cclim_pkg::TIME_BITS-1:0]  gap,
	input  logic                             work,
	output cclim_pkg::chan_dec_t             dec
);

	logic                             changed;
	logic                             zero_cross;
	logic [cclim_pkg::COUNT_BITS-1:0] move;
	logic [cclim_pkg::TIME_BITS-1:0]  elapsed;
	logic                             fire;

	// distance from the alert point and wrapping elapsed time
	always_comb begin
		changed    = (prev != cur);
		zero_cross = (prev == '0) != (cur == '0);
		move       = (cur > alert_cnt) ? (cur - alert_cnt) : (alert_cnt - cur);
		elapsed    = now - alert_time;
		fire       = changed && (zero_cross || (move >= delta && elapsed >= gap));
		dec.fire   = fire;
		dec.emit   = fire || (changed && work);
		dec.rising = (cur > prev);
	end

endmodule

/* bench/cclim_alert_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cclim_alert_checker: word predictor and scoreboard for the alert limiter
// Watches the sample, alert and register ports, keeps its own copy of the
// baselines, alert points and registers, queues the alert words that every
// accepted sample must cause and compares each word that leaves the block.
// ----------------------------------------------------------------------------
module cclim_alert_checker
	import cclim_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [TIME_BITS-1:0]  now_ms,
	input  logic [COUNT_BITS-1:0] unread_count,
	input  logic [COUNT_BITS-1:0] undone_count,
	input  logic [COUNT_BITS-1:0] expired_count,
	input  logic [COUNT_BITS-1:0] group_delayed_count,
	input  logic                  work_session,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [1:0]            channel,
	input  logic                  suppressed,
	input  logic [COUNT_BITS-1:0] count_value,
	input  logic                  rising,
	input  logic                  last_of_run,
	input  logic                  cfg_we,
	input  logic [IDX_BITS-1:0]   cfg_index,
	input  logic [CFG_BITS-1:0]   cfg_data,
	output int                    fail_count,
	output int                    words_pending
);

	localparam int SHOW_LIMIT = 10;

	typedef struct packed {
		logic [1:0]            channel;
		logic                  suppressed;
		logic [COUNT_BITS-1:0] count_value;
		logic                  rising;
		logic                  last;
	} alert_word_t;

	alert_word_t alert_q[$];

	// register copy
	logic [COUNT_BITS-1:0] delta_cfg [NUM_CHAN];
	logic [TIME_BITS-1:0]  gap_cfg   [NUM_CHAN];
	logic                  grp_mode;

	// baselines and alert points
	logic                  have_baseline;
	logic [COUNT_BITS-1:0] seen_unread, seen_undone, seen_expired, seen_grp;
	logic [COUNT_BITS-1:0] alert_cnt [NUM_CHAN];
	logic [TIME_BITS-1:0]  alert_ms  [NUM_CHAN];

	// Decide one channel: real alert, suppressed notice or nothing.
	function automatic void judge_channel(input logic [1:0] ch,
			input logic [COUNT_BITS-1:0] before_cnt, input logic [COUNT_BITS-1:0] cur,
			input logic [TIME_BITS-1:0] stamp, input logic work);
		logic                  crossed;
		logic [COUNT_BITS-1:0] moved;
		logic [TIME_BITS-1:0]  waited;
		logic                  fire;
		alert_word_t           w;
		if (before_cnt == cur)
			return;
		crossed = (before_cnt == '0) != (cur == '0);
		moved = (cur > alert_cnt[ch]) ? cur - alert_cnt[ch] : alert_cnt[ch] - cur;
		// elapsed time wraps with the timestamp
		waited = stamp - alert_ms[ch];
		fire = crossed || (moved >= delta_cfg[ch] && waited >= gap_cfg[ch]);
		if (fire) begin
			alert_cnt[ch] = cur;
			alert_ms[ch] = stamp;
		end else if (!work) begin
			return;
		end
		w.channel = ch;
		w.suppressed = !fire;
		w.count_value = cur;
		w.rising = cur > before_cnt;
		w.last = 1'b0;
		alert_q.push_back(w);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alert_word_t           want;
		logic [COUNT_BITS-1:0] late_now, late_before;
		int                    n_before;
		if (!arst_n) begin
			delta_cfg[CH_UNREAD] = RST_UNREAD_DELTA;
			delta_cfg[CH_UNDONE] = RST_UNDONE_DELTA;
			delta_cfg[CH_LATE] = RST_LATE_DELTA;
			gap_cfg[CH_UNREAD] = RST_UNREAD_GAP;
			gap_cfg[CH_UNDONE] = RST_UNDONE_GAP;
			gap_cfg[CH_LATE] = RST_LATE_GAP;
			grp_mode = 1'b0;
			have_baseline = 1'b0;
			seen_unread = '0;
			seen_undone = '0;
			seen_expired = '0;
			seen_grp = '0;
			for (int i = 0; i < NUM_CHAN; i++) begin
				alert_cnt[i] = '0;
				alert_ms[i] = '0;
			end
			alert_q.delete();
			fail_count = 0;
			words_pending = 0;
		end else begin
			// compare the word leaving the block with the oldest expectation
			if (out_valid && out_ready) begin
				if (alert_q.size() == 0) begin
					fail_count++;
					if (fail_count <= SHOW_LIMIT)
						$display("%0t: unexpected word ch=%0d sup=%0d cnt=%0d rise=%0d last=%0d",
							$time, channel, suppressed, count_value, rising, last_of_run);
				end else begin
					want = alert_q.pop_front();
					if (channel !== want.channel || suppressed !== want.suppressed ||
							count_value !== want.count_value || rising !== want.rising ||
							last_of_run !== want.last) begin
						fail_count++;
						if (fail_count <= SHOW_LIMIT)
							$display({"%0t: word mismatch: exp ch=%0d sup=%0d cnt=%0d rise=%0d",
								" last=%0d, got ch=%0d sup=%0d cnt=%0d rise=%0d last=%0d"},
								$time, want.channel, want.suppressed, want.count_value,
								want.rising, want.last, channel, suppressed, count_value,
								rising, last_of_run);
					end
				end
			end

			// predict the words of an accepted sample
			if (in_valid && in_ready) begin
				late_now = grp_mode ? group_delayed_count : expired_count;
				late_before = grp_mode ? seen_grp : seen_expired;
				if (!have_baseline) begin
					// first sample only sets the alert points
					have_baseline = 1'b1;
					alert_cnt[CH_UNREAD] = unread_count;
					alert_cnt[CH_UNDONE] = undone_count;
					alert_cnt[CH_LATE] = late_now;
					for (int i = 0; i < NUM_CHAN; i++)
						alert_ms[i] = now_ms;
				end else begin
					n_before = alert_q.size();
					judge_channel(CH_UNREAD, seen_unread, unread_count, now_ms, work_session);
					judge_channel(CH_UNDONE, seen_undone, undone_count, now_ms, work_session);
					judge_channel(CH_LATE, late_before, late_now, now_ms, work_session);
					if (alert_q.size() > n_before)
						alert_q[alert_q.size() - 1].last = 1'b1;
				end
				// all four counts become the previous sample
				seen_unread = unread_count;
				seen_undone = undone_count;
				seen_expired = expired_count;
				seen_grp = group_delayed_count;
			end

			// follow register writes; unknown indexes are dropped
			if (cfg_we) begin
				case (cfg_index)
					REG_UNREAD_DELTA: delta_cfg[CH_UNREAD] = cfg_data[COUNT_BITS-1:0];
					REG_UNDONE_DELTA: delta_cfg[CH_UNDONE] = cfg_data[COUNT_BITS-1:0];
					REG_LATE_DELTA:   delta_cfg[CH_LATE] = cfg_data[COUNT_BITS-1:0];
					REG_UNREAD_GAP:   gap_cfg[CH_UNREAD] = cfg_data[TIME_BITS-1:0];
					REG_UNDONE_GAP:   gap_cfg[CH_UNDONE] = cfg_data[TIME_BITS-1:0];
					REG_LATE_GAP:     gap_cfg[CH_LATE] = cfg_data[TIME_BITS-1:0];
					REG_GROUP_MODE:   grp_mode = cfg_data[0];
					default: ;
				endcase
			end

			words_pending = alert_q.size();
		end
	end

endmodule

/* bench/tb_count_change_alert_limiter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_count_change_alert_limiter: testbench of the count change alert limiter
// Sends a directed run of samples (baseline, zero crossings, delta and gap
// limits, time wrap, count extremes, late source switch) and then random
// samples under several register settings, with bursty input, a stalling
// receiver and long receiver hold-offs. A checker module scores every word.
// ----------------------------------------------------------------------------
module tb_count_change_alert_limiter;
	import cclim_pkg::*;

	localparam int HALF_PERIOD     = 4;
	localparam int RESET_CYCLES    = 4;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 48;
	localparam int HOLD_CYCLES     = 250;
	localparam int SETTLE_CYCLES   = 8;
	localparam int CYCLE_LIMIT     = 400000;
	localparam logic [IDX_BITS-1:0] REG_SPARE = 3'd7;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [TIME_BITS-1:0]  now_ms = '0;
	logic [COUNT_BITS-1:0] unread_count = '0;
	logic [COUNT_BITS-1:0] undone_count = '0;
	logic [COUNT_BITS-1:0] expired_count = '0;
	logic [COUNT_BITS-1:0] group_delayed_count = '0;
	logic                  work_session = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [1:0]            channel;
	logic                  suppressed;
	logic [COUNT_BITS-1:0] count_value;
	logic                  rising;
	logic                  last_of_run;
	logic                  cfg_we = 1'b0;
	logic [IDX_BITS-1:0]   cfg_index = '0;
	logic [CFG_BITS-1:0]   cfg_data = '0;

	int fail_count;
	int words_pending;
	int cycles = 0;

	// receiver state
	int       hold_req = 0;
	int       hold_seen = 0;
	int       hold_left = 0;
	int       rx_left = 0;
	rx_mode_t rx_mode = RX_OPEN;

	// random sample state
	logic [TIME_BITS-1:0]  clock_ms;
	logic [COUNT_BITS-1:0] rnd_unread, rnd_undone, rnd_expired, rnd_grp;

	count_change_alert_limiter dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .now_ms(now_ms),
		.unread_count(unread_count), .undone_count(undone_count),
		.expired_count(expired_count), .group_delayed_count(group_delayed_count),
		.work_session(work_session),
		.out_valid(out_valid), .out_ready(out_ready), .channel(channel),
		.suppressed(suppressed), .count_value(count_value), .rising(rising),
		.last_of_run(last_of_run),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	cclim_alert_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .now_ms(now_ms),
		.unread_count(unread_count), .undone_count(undone_count),
		.expired_count(expired_count), .group_delayed_count(group_delayed_count),
		.work_session(work_session),
		.out_valid(out_valid), .out_ready(out_ready), .channel(channel),
		.suppressed(suppressed), .count_value(count_value), .rising(rising),
		.last_of_run(last_of_run),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .words_pending(words_pending)
	);

	always #HALF_PERIOD clk = ~clk;

	// stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// receiver: long hold-off on request, else a changing stall pattern
	always @(posedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
				rx_left <= $urandom_range(8, 64);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_mode)
				RX_OPEN:   out_ready <= 1'b1;
				RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
				RX_BEAT:   out_ready <= rx_left[1];
			endcase
		end
	end

	// Offer one sample and hold it until the block takes it.
	task automatic send_sample(input logic [TIME_BITS-1:0] t, input logic [COUNT_BITS-1:0] u,
			input logic [COUNT_BITS-1:0] d, input logic [COUNT_BITS-1:0] e,
			input logic [COUNT_BITS-1:0] g, input logic w);
		in_valid <= 1'b1;
		now_ms <= t;
		unread_count <= u;
		undone_count <= d;
		expired_count <= e;
		group_delayed_count <= g;
		work_session <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic idle(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Wait until every expected word has left and the block has gone quiet.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// Write every register, junk in the unused upper bits of the delta and mode registers, then a dead index.
	task automatic write_regs(input logic [COUNT_BITS-1:0] d0, input logic [COUNT_BITS-1:0] d1,
			input logic [COUNT_BITS-1:0] d2, input logic [TIME_BITS-1:0] g0,
			input logic [TIME_BITS-1:0] g1, input logic [TIME_BITS-1:0] g2, input logic mode);
		put_reg(REG_UNREAD_DELTA, {16'($urandom), d0});
		put_reg(REG_UNDONE_DELTA, {16'($urandom), d1});
		put_reg(REG_LATE_DELTA, {16'($urandom), d2});
		put_reg(REG_UNREAD_GAP, g0);
		put_reg(REG_UNDONE_GAP, g1);
		put_reg(REG_LATE_GAP, g2);
		put_reg(REG_GROUP_MODE, {31'($urandom), mode});
		put_reg(REG_SPARE, $urandom);
		cfg_we <= 1'b0;
	endtask

	// Move a count: mostly hold, step or hit zero, sometimes jump anywhere.
	function automatic logic [COUNT_BITS-1:0] next_count(input logic [COUNT_BITS-1:0] c);
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return c;
		if (r < 50)
			return '0;
		if (r < 75)
			return ($urandom_range(0, 1) != 0) ? c + 16'($urandom_range(1, 4))
				: c - 16'($urandom_range(1, 4));
		if (r < 85)
			return ($urandom_range(0, 1) != 0) ? c + 16'($urandom_range(5, 200))
				: c - 16'($urandom_range(5, 200));
		if (r < 95)
			return 16'($urandom);
		return '1;
	endfunction

	task automatic send_random();
		int r;
		r = $urandom_range(0, 99);
		// advance time: short steps, gap-sized steps, or a wide jump
		if (r < 40)
			clock_ms = clock_ms + $urandom_range(0, 5000);
		else if (r < 80)
			clock_ms = clock_ms + $urandom_range(100000, 1200000);
		else if (r < 95)
			clock_ms = clock_ms + $urandom_range(0, 32'h00FF_FFFF);
		else
			clock_ms = $urandom;
		rnd_unread = next_count(rnd_unread);
		rnd_undone = next_count(rnd_undone);
		rnd_expired = next_count(rnd_expired);
		rnd_grp = next_count(rnd_grp);
		send_sample(clock_ms, rnd_unread, rnd_undone, rnd_expired, rnd_grp,
			$urandom_range(0, 3) != 0);
	endtask

	initial begin
		int  burst_left;
		bit  no_gaps;
		burst_left = 0;
		clock_ms = $urandom;
		rnd_unread = '0;
		rnd_undone = '0;
		rnd_expired = '0;
		rnd_grp = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed run at reset register values
		send_sample(32'd1000, 16'd5, 16'd0, 16'd2, 16'd7, 1'b1);     // baseline only
		send_sample(32'd1000, 16'd5, 16'd0, 16'd2, 16'd7, 1'b1);     // no change
		send_sample(32'd2000, 16'd0, 16'd0, 16'd2, 16'd7, 1'b1);     // unread falls to zero
		idle(2);
		send_sample(32'd3000, 16'd0, 16'd1, 16'd2, 16'd7, 1'b1);     // undone leaves zero
		send_sample(32'd4000, 16'd0, 16'd2, 16'd3, 16'd7, 1'b1);     // under delta / gap
		send_sample(32'd5000, 16'd0, 16'd3, 16'd4, 16'd0, 1'b0);     // silent, no session
		send_sample(32'd1000000, 16'd0, 16'd5, 16'd5, 16'd0, 1'b1);  // delta and gap met
		send_sample(32'd1000001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		send_sample(32'hFFFF_FF00, 16'hFFFE, 16'd0, 16'd0, 16'd0, 1'b1);
		send_sample(32'h0000_0100, 16'd65000, 16'd1, 16'd3, 16'd9, 1'b1); // time wraps
		send_sample(32'h0000_0200, 16'd65000, 16'd1, 16'd3, 16'd9, 1'b1);
		drain();

		// late channel switches to the group counter
		write_regs(RST_UNREAD_DELTA, RST_UNDONE_DELTA, RST_LATE_DELTA,
			RST_UNREAD_GAP, RST_UNDONE_GAP, RST_LATE_GAP, 1'b1);
		send_sample(32'h0000_0300, 16'd65000, 16'd1, 16'd3, 16'd9, 1'b1);
		send_sample(32'h0000_0400, 16'd65000, 16'd1, 16'd0, 16'd12, 1'b1);
		send_sample(32'h0000_0500, 16'd0, 16'd0, 16'd7, 16'd0, 1'b1);     // three alerts
		drain();

		// lowest limits, back to the expired counter
		write_regs('0, '0, '0, '0, '0, '0, 1'b0);
		send_sample(32'h0000_0600, 16'd0, 16'd0, 16'd5, 16'd0, 1'b1);
		send_sample(32'h0000_0600, 16'd1, 16'd1, 16'd6, 16'd0, 1'b0);
		drain();

		// random phases, each under its own register setting
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: write_regs('0, '0, '0, '0, '0, '0, 1'b0);
				1: write_regs('1, '1, '1, '1, '1, '1, 1'b1);
				2: write_regs(RST_UNREAD_DELTA, RST_UNDONE_DELTA, RST_LATE_DELTA,
					RST_UNREAD_GAP, RST_UNDONE_GAP, RST_LATE_GAP, 1'b0);
				3: write_regs(16'($urandom_range(0, 10)), 16'($urandom_range(0, 10)),
					16'($urandom_range(0, 10)), $urandom_range(0, 2000000),
					$urandom_range(0, 2000000), $urandom_range(0, 2000000), 1'b1);
				4: write_regs(16'd1, 16'd1, 16'd1, 32'd1, 32'd1, 32'd1, 1'b0);
				5: write_regs(16'($urandom), 16'($urandom), 16'($urandom),
					$urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
				default: write_regs(16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
					16'($urandom_range(0, 6)), $urandom_range(0, 1500000),
					$urandom_range(0, 1500000), $urandom_range(0, 1500000), 1'(p));
			endcase

			// hold the receiver off and keep offering so the block backs up
			no_gaps = (p == 2 || p == 5);
			if (no_gaps)
				hold_req <= hold_req + 1;

			burst_left = 0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 12);
					if (!no_gaps && $urandom_range(0, 2) != 0)
						idle($urandom_range(1, 8));
				end
				burst_left--;
				send_random();
			end
			drain();
		end

		if (fail_count == 0 && words_pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

/* files.f */
src/cclim_pkg.sv
src/cclim_chan.sv
src/count_change_alert_limiter.sv
bench/cclim_alert_checker.sv
bench/tb_count_change_alert_limiter.sv
